[hdl/gfs_pkg.sv]
// Shared types, constants and reaction tables of the four-species stochastic step core.
package gfs_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int FRAC_BITS   = 32;
	localparam int CROWD_LIMIT = 2000;
	localparam int NUM_REACT   = 17;
	localparam int NUM_REGS    = 8;
	localparam int REG_W       = 48;
	localparam int LOG_FRAC    = FRAC_BITS + 8;
	localparam int LN_SHIFT    = LOG_FRAC + 32 - FRAC_BITS;
	localparam int DIV_STEPS   = 64 + FRAC_BITS;

	localparam logic [63:0]      BIG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]      HAZ_MAX  = 64'h07FF_FFFF_FFFF_FFFF;
	localparam logic [REG_W-1:0] TIME_MAX = {REG_W{1'b1}};
	localparam logic [31:0]      LN2_Q32  = 32'hB172_17F8;
	localparam logic [REG_W-1:0] ONE_FIX  = REG_W'(1) << FRAC_BITS;

	// Register indexes.
	localparam logic [2:0] REG_FUSION   = 3'd0;
	localparam logic [2:0] REG_FISSION  = 3'd1;
	localparam logic [2:0] REG_TARGET   = 3'd2;
	localparam logic [2:0] REG_GAIN     = 3'd3;
	localparam logic [2:0] REG_BASE     = 3'd4;
	localparam logic [2:0] REG_FUSED_SC = 3'd5;
	localparam logic [2:0] REG_MUT_WGT  = 3'd6;
	localparam logic [2:0] REG_MUT_DEG  = 3'd7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Count deltas, three-bit two's complement.
	localparam logic [2:0] DM2 = 3'b110;
	localparam logic [2:0] DM1 = 3'b111;
	localparam logic [2:0] DZ  = 3'b000;
	localparam logic [2:0] DP1 = 3'b001;
	localparam logic [2:0] DP2 = 3'b010;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [3:0] {
		S_IDLE, S_OP, S_MUL, S_POST, S_SCAN, S_CHECK, S_NORM,
		S_SQ, S_SQ_POST, S_LN, S_LN_POST, S_DIV, S_APPLY, S_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_PW, OP_PM, OP_P2, OP_P3, OP_P14, OP_P15, OP_P16,
		OP_SM, OP_GAIN, OP_DX, OP_DQ,
		OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_H5, OP_H6, OP_H7, OP_H8,
		OP_H9, OP_H10, OP_H11, OP_H12, OP_H13, OP_H14, OP_H15, OP_H16,
		OP_PICK
	} op_t;

	typedef enum logic [2:0] {
		STAT_STEPPED   = 3'd0,
		STAT_LOADED    = 3'd1,
		STAT_EXTINCT   = 3'd2,
		STAT_NEG       = 3'd3,
		STAT_OVF       = 3'd4,
		STAT_ZERO_RATE = 3'd5
	} status_t;

	typedef enum logic [1:0] {SH_0, SH_1, SH_F, SH_LN} shift_t;

	// Truncating shift of a full product, saturated at the hazard or the big cap.
	function automatic logic [63:0] mul_post(logic [127:0] p, shift_t s, logic haz);
		logic [127:0] v;
		logic [63:0]  cap;
		case (s)
			SH_0:    v = p;
			SH_1:    v = p >> 1;
			SH_F:    v = p >> FRAC_BITS;
			SH_LN:   v = p >> LN_SHIFT;
			default: v = p;
		endcase
		cap = haz ? HAZ_MAX : BIG_MAX;
		return (v > {64'd0, cap}) ? cap : v[63:0];
	endfunction

	// Deltas of one reaction, packed {mut_fused, mut_single, wild_fused, wild_single}.
	function automatic logic [11:0] step_delta(logic [4:0] j);
		case (j)
			5'd0:    return {DZ,  DZ,  DP2, DM2};
			5'd1:    return {DP2, DM2, DZ,  DZ};
			5'd2:    return {DZ,  DZ,  DP1, DM1};
			5'd3:    return {DP1, DM1, DZ,  DZ};
			5'd4:    return {DZ,  DZ,  DM1, DP1};
			5'd5:    return {DM1, DP1, DZ,  DZ};
			5'd6:    return {DZ,  DZ,  DP1, DZ};
			5'd7:    return {DP1, DZ,  DZ,  DZ};
			5'd8:    return {DZ,  DZ,  DP2, DM1};
			5'd9:    return {DP2, DM1, DZ,  DZ};
			5'd10:   return {DZ,  DZ,  DM1, DZ};
			5'd11:   return {DM1, DZ,  DZ,  DZ};
			5'd12:   return {DZ,  DZ,  DZ,  DM1};
			5'd13:   return {DZ,  DM1, DZ,  DZ};
			5'd14:   return {DP1, DM1, DZ,  DZ};
			5'd15:   return {DZ,  DZ,  DP1, DM1};
			5'd16:   return {DP1, DM1, DP1, DM1};
			default: return {DZ,  DZ,  DZ,  DZ};
		endcase
	endfunction

endpackage

[hdl/gillespie_four_species_step_core.sv]
// Four-species Gillespie direct-method step core built around one shared 32x32 multiplier.
// A step works through the shared multiplier (29 products of one to four partial products
// each, then 40 squarings for the logarithm) and a bit-serial divider; a rejected or
// zero-rate step stops before the logarithm. It takes one transaction at a time; a result
// may wait at the output while the next transaction is taken. Reset clears counts, time,
// crowd flag and loads defaults.
module gillespie_four_species_step_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [gfs_pkg::REG_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     command,
	input  logic [15:0]              load_wild_single,
	input  logic [15:0]              load_wild_fused,
	input  logic [15:0]              load_mut_single,
	input  logic [15:0]              load_mut_fused,
	input  logic [31:0]              uniform_time,
	input  logic [31:0]              uniform_pick,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [15:0]              wild_single,
	output logic [15:0]              wild_fused,
	output logic [15:0]              mut_single,
	output logic [15:0]              mut_fused,
	output logic [gfs_pkg::REG_W-1:0] sim_time,
	output logic [4:0]               chosen_reaction,
	output logic [2:0]               status,
	output logic                     crowd_warning
);
	import gfs_pkg::*;

	// Architectural state: rate registers, the four counts, time and the crowd flag.
	logic [REG_W-1:0] cfg_q [NUM_REGS];
	count_t           c_q [4];
	logic [REG_W-1:0] time_q;
	logic             crowd_q;
	status_t          status_q;
	logic [4:0]       chosen_q;

	state_t state_q, state_d, ret_q;
	op_t    op_q;

	// Shared multiplier: operands, pending partial products and the 128-bit accumulator.
	logic [63:0]  mul_a_q, mul_b_q;
	logic [3:0]   mask_q;
	logic [63:0]  prod_q;
	logic [1:0]   off_q;
	logic         prod_v_q;
	logic [127:0] acc_q;

	// Intermediate results of one step.
	logic [31:0]   pair_q [7];
	logic [62:0]   s_q, rr_q, dx_q, dq_q;
	logic [58:0]   haz_q [NUM_REACT];
	logic [63:0]   total_q, th_hi_q, cum_q;
	logic [4:0]    scan_q, j_q;
	count_t        newc_q [4];
	logic [31:0]   pick_q, ut_q, m_q;
	logic [4:0]    shcnt_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [5:0]    it_q;
	logic [63:0]   numsh_q, rem_q;
	logic [REG_W-1:0] quo_q;
	logic          over_q;
	logic [6:0]    div_cnt_q;

	// Output register.
	logic          out_valid_q;
	count_t        out_c_q [4];
	logic [REG_W-1:0] out_time_q;
	logic [4:0]    out_chosen_q;
	status_t       out_status_q;
	logic          out_crowd_q;

	// Combinational helpers.
	logic [63:0]  start_a, start_b;
	logic [63:0]  dec_a, dec_b;
	shift_t       dec_sh;
	logic         dec_haz;
	logic [63:0]  post_res;
	logic [63:0]  total_next;
	logic [4:0]   haz_idx;
	logic [2:0]   pair_idx;
	logic [63:0]  mu, gamma, beta, kappa;
	logic         fb_ge;
	logic [62:0]  fb_diff;
	logic [63:0]  cum_next;
	logic         scan_hit;
	logic [11:0]  delta_row;
	logic         any_neg, any_ovf;
	count_t       applied [4];
	logic [31:0]  pa, pb;
	logic [32:0]  sq_t;
	logic [LOG_FRAC+5:0] nl2;
	logic [64:0]  r_sh, r_sub;
	logic         div_ge;
	logic [REG_W-1:0] dt;
	logic [REG_W:0]   tsum;
	logic [17:0]  crowd_sum;
	logic         fin_go;

	assign mu    = 64'(cfg_q[REG_BASE]);
	assign gamma = 64'(cfg_q[REG_FUSION]);
	assign beta  = 64'(cfg_q[REG_FISSION]);
	assign kappa = 64'(cfg_q[REG_TARGET]);

	// Feedback comparison of the set point against the weighted population sum.
	assign fb_ge   = kappa >= {1'b0, s_q};
	assign fb_diff = fb_ge ? (kappa[62:0] - s_q) : (s_q - kappa[62:0]);

	assign haz_idx  = 5'(op_q) - 5'(OP_H0);
	assign pair_idx = 3'(op_q);

	// Operand decode for the product list; each hazard is a count term times its rate.
	always_comb begin
		dec_a   = '0;
		dec_b   = '0;
		dec_sh  = SH_0;
		dec_haz = 1'b0;
		case (op_q)
			OP_PW: begin
				dec_a  = 64'(c_q[0]);
				dec_b  = (c_q[0] == '0) ? 64'd0 : 64'(c_q[0] - count_t'(1));
				dec_sh = SH_1;
			end
			OP_PM: begin
				dec_a  = 64'(c_q[2]);
				dec_b  = (c_q[2] == '0) ? 64'd0 : 64'(c_q[2] - count_t'(1));
				dec_sh = SH_1;
			end
			OP_P2:  begin dec_a = 64'(c_q[1]); dec_b = 64'(c_q[0]); end
			OP_P3:  begin dec_a = 64'(c_q[3]); dec_b = 64'(c_q[2]); end
			OP_P14: begin dec_a = 64'(c_q[1]); dec_b = 64'(c_q[2]); end
			OP_P15: begin dec_a = 64'(c_q[3]); dec_b = 64'(c_q[0]); end
			OP_P16: begin dec_a = 64'(c_q[0]); dec_b = 64'(c_q[2]); end
			OP_SM: begin
				dec_a = 64'(c_q[2]) + 64'(c_q[3]);
				dec_b = 64'(cfg_q[REG_MUT_WGT]);
			end
			OP_GAIN: begin
				dec_a  = 64'(cfg_q[REG_GAIN]);
				dec_b  = {1'b0, fb_diff};
				dec_sh = SH_F;
			end
			OP_DX: begin dec_a = 64'(cfg_q[REG_FUSED_SC]); dec_b = mu; dec_sh = SH_F; end
			OP_DQ: begin dec_a = mu; dec_b = 64'(cfg_q[REG_MUT_DEG]); dec_sh = SH_F; end
			OP_H0:  begin dec_a = 64'(pair_q[0]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_H1:  begin dec_a = 64'(pair_q[1]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_H2:  begin dec_a = 64'(pair_q[2]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_H3:  begin dec_a = 64'(pair_q[3]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_H4:  begin dec_a = 64'(c_q[1]);    dec_b = beta;          dec_haz = 1'b1; end
			OP_H5:  begin dec_a = 64'(c_q[3]);    dec_b = beta;          dec_haz = 1'b1; end
			OP_H6:  begin dec_a = 64'(c_q[1]);    dec_b = {1'b0, rr_q};  dec_haz = 1'b1; end
			OP_H7:  begin dec_a = 64'(c_q[3]);    dec_b = {1'b0, rr_q};  dec_haz = 1'b1; end
			OP_H8:  begin dec_a = 64'(c_q[0]);    dec_b = {1'b0, rr_q};  dec_haz = 1'b1; end
			OP_H9:  begin dec_a = 64'(c_q[2]);    dec_b = {1'b0, rr_q};  dec_haz = 1'b1; end
			OP_H10: begin dec_a = 64'(c_q[1]);    dec_b = {1'b0, dx_q};  dec_haz = 1'b1; end
			OP_H11: begin dec_a = 64'(c_q[3]);    dec_b = {1'b0, dx_q};  dec_haz = 1'b1; end
			OP_H12: begin dec_a = 64'(c_q[0]);    dec_b = mu;            dec_haz = 1'b1; end
			OP_H13: begin dec_a = 64'(c_q[2]);    dec_b = {1'b0, dq_q};  dec_haz = 1'b1; end
			OP_H14: begin dec_a = 64'(pair_q[4]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_H15: begin dec_a = 64'(pair_q[5]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_H16: begin dec_a = 64'(pair_q[6]); dec_b = gamma;         dec_haz = 1'b1; end
			OP_PICK: begin dec_a = 64'(pick_q); dec_b = total_q; end
			default: begin dec_a = '0; dec_b = '0; end
		endcase
	end

	assign post_res   = mul_post(acc_q, dec_sh, dec_haz);
	assign total_next = total_q + post_res;

	// Partial product selection: lowest pending quarter first.
	always_comb begin
		if (mask_q[0]) begin
			pa = mul_a_q[31:0];  pb = mul_b_q[31:0];
		end else if (mask_q[1]) begin
			pa = mul_a_q[31:0];  pb = mul_b_q[63:32];
		end else if (mask_q[2]) begin
			pa = mul_a_q[63:32]; pb = mul_b_q[31:0];
		end else begin
			pa = mul_a_q[63:32]; pb = mul_b_q[63:32];
		end
	end

	// Cumulative hazard scan: the pick threshold is compared a reaction per cycle.
	assign cum_next = cum_q + 64'(haz_q[scan_q]);
	assign scan_hit = th_hi_q < cum_next;

	// Bounds check of the chosen reaction on all four counts.
	assign delta_row = step_delta(j_q);
	always_comb begin
		logic signed [17:0] sum;
		any_neg = 1'b0;
		any_ovf = 1'b0;
		for (int i = 0; i < 4; i++) begin
			sum = $signed({2'b00, c_q[i]}) + 18'($signed(delta_row[3*i +: 3]));
			applied[i] = sum[COUNT_BITS-1:0];
			if (sum[17]) any_neg = 1'b1;
			else if (sum[16:COUNT_BITS] != '0) any_ovf = 1'b1;
		end
	end

	// Logarithm pieces: squared mantissa and -log2 before scaling by ln 2.
	assign sq_t = acc_q[63:31];
	assign nl2  = ((LOG_FRAC+6)'({1'b0, shcnt_q} + 6'd1) << LOG_FRAC) - (LOG_FRAC+6)'(frac_q);

	// One restoring divider step per cycle.
	assign r_sh   = {rem_q, numsh_q[63]};
	assign div_ge = r_sh >= {1'b0, total_q};
	assign r_sub  = r_sh - {1'b0, total_q};

	assign dt   = over_q ? TIME_MAX : quo_q;
	assign tsum = {1'b0, time_q} + {1'b0, dt};

	assign crowd_sum = 18'(c_q[0]) + 18'(c_q[1]) + 18'(c_q[2]) + 18'(c_q[3]);
	assign fin_go    = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = (command == CMD_STEP) ? S_OP : S_FIN;
			S_OP:      state_d = S_MUL;
			S_MUL:     if (mask_q == '0 && prod_v_q) state_d = ret_q;
			S_POST: begin
				if (op_q == OP_PICK) state_d = S_SCAN;
				else if (op_q == OP_H16 && total_next == '0) state_d = S_FIN;
				else state_d = S_OP;
			end
			S_SCAN:    if (scan_hit || scan_q == 5'(NUM_REACT - 1)) state_d = S_CHECK;
			S_CHECK:   state_d = (any_neg || any_ovf) ? S_FIN : S_NORM;
			S_NORM:    if (m_q[31]) state_d = S_SQ;
			S_SQ:      state_d = S_MUL;
			S_SQ_POST: state_d = (it_q == 6'(LOG_FRAC - 1)) ? S_LN : S_SQ;
			S_LN:      state_d = S_MUL;
			S_LN_POST: state_d = S_DIV;
			S_DIV:     if (div_cnt_q == 7'(DIV_STEPS - 1)) state_d = S_APPLY;
			S_APPLY:   state_d = S_FIN;
			S_FIN:     if (fin_go) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and multiplier start operands.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_SQ: begin start_a = 64'(m_q); start_b = 64'(m_q); end
			S_LN: begin start_a = 64'(nl2); start_b = 64'(LN2_Q32); end
			default: begin start_a = dec_a; start_b = dec_b; end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
			cfg_q[REG_MUT_WGT] <= ONE_FIX;
			cfg_q[REG_MUT_DEG] <= ONE_FIX;
			for (int i = 0; i < 4; i++) c_q[i] <= '0;
			time_q   <= '0;
			crowd_q  <= 1'b0;
			status_q <= STAT_STEPPED;
			chosen_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q[cfg_index] <= cfg_data;

			if (state_q == S_FIN && fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid && command == CMD_LOAD) begin
						c_q[0]   <= load_wild_single;
						c_q[1]   <= load_wild_fused;
						c_q[2]   <= load_mut_single;
						c_q[3]   <= load_mut_fused;
						time_q   <= '0;
						crowd_q  <= 1'b0;
						status_q <= STAT_LOADED;
						chosen_q <= '0;
					end else if (in_valid) begin
						if (crowd_sum > 18'(CROWD_LIMIT)) crowd_q <= 1'b1;
					end
				end
				S_POST: begin
					if (op_q == OP_H16 && total_next == '0) begin
						status_q <= STAT_ZERO_RATE;
						chosen_q <= '0;
					end
				end
				S_CHECK: begin
					if (any_neg || any_ovf) begin
						status_q <= any_neg ? STAT_NEG : STAT_OVF;
						chosen_q <= '0;
					end
				end
				S_APPLY: begin
					for (int i = 0; i < 4; i++) c_q[i] <= newc_q[i];
					time_q   <= tsum[REG_W] ? TIME_MAX : tsum[REG_W-1:0];
					chosen_q <= j_q;
					status_q <= ((newc_q[0] | newc_q[1] | newc_q[2] | newc_q[3]) == '0)
						? STAT_EXTINCT : STAT_STEPPED;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pick_q  <= uniform_pick;
				ut_q    <= (uniform_time == '0) ? 32'd1 : uniform_time;
				op_q    <= OP_PW;
				total_q <= '0;
			end
			S_OP, S_SQ, S_LN: begin
				mul_a_q  <= start_a;
				mul_b_q  <= start_b;
				mask_q   <= {(|start_a[63:32]) & (|start_b[63:32]), |start_a[63:32],
					|start_b[63:32], 1'b1};
				acc_q    <= '0;
				prod_v_q <= 1'b0;
				ret_q    <= (state_q == S_OP) ? S_POST :
					(state_q == S_SQ) ? S_SQ_POST : S_LN_POST;
			end
			S_MUL: begin
				prod_q   <= pa * pb;
				prod_v_q <= |mask_q;
				if (mask_q[0]) begin
					mask_q[0] <= 1'b0; off_q <= 2'd0;
				end else if (mask_q[1]) begin
					mask_q[1] <= 1'b0; off_q <= 2'd1;
				end else if (mask_q[2]) begin
					mask_q[2] <= 1'b0; off_q <= 2'd1;
				end else begin
					mask_q[3] <= 1'b0; off_q <= 2'd2;
				end
				if (prod_v_q) begin
					case (off_q)
						2'd0:    acc_q <= acc_q + {64'd0, prod_q};
						2'd1:    acc_q <= acc_q + {32'd0, prod_q, 32'd0};
						default: acc_q <= acc_q + {prod_q, 64'd0};
					endcase
				end
			end
			S_POST: begin
				op_q <= op_t'(op_q + 5'd1);
				case (op_q)
					OP_PW, OP_PM, OP_P2, OP_P3, OP_P14, OP_P15, OP_P16:
						pair_q[pair_idx] <= post_res[31:0];
					OP_SM: begin
						logic [63:0] ssum;
						ssum = (64'(c_q[0]) + 64'(c_q[1])) << FRAC_BITS;
						ssum = ssum + post_res;
						s_q  <= ssum[63] ? BIG_MAX[62:0] : ssum[62:0];
					end
					OP_GAIN: begin
						logic [63:0] up;
						up = mu + post_res;
						if (fb_ge) rr_q <= up[63] ? BIG_MAX[62:0] : up[62:0];
						else rr_q <= (mu > post_res) ? 63'(mu - post_res) : '0;
					end
					OP_DX: dx_q <= post_res[62:0];
					OP_DQ: dq_q <= post_res[62:0];
					OP_PICK: begin
						th_hi_q <= acc_q[95:32];
						scan_q  <= '0;
						cum_q   <= '0;
					end
					default: begin
						haz_q[haz_idx] <= post_res[58:0];
						total_q        <= total_next;
					end
				endcase
			end
			S_SCAN: begin
				cum_q  <= cum_next;
				scan_q <= scan_q + 5'd1;
				j_q    <= scan_q;
			end
			S_CHECK: begin
				for (int i = 0; i < 4; i++) newc_q[i] <= applied[i];
				m_q     <= ut_q;
				shcnt_q <= '0;
			end
			S_NORM: begin
				if (!m_q[31]) begin
					m_q     <= {m_q[30:0], 1'b0};
					shcnt_q <= shcnt_q + 5'd1;
				end
				it_q   <= '0;
				frac_q <= '0;
			end
			S_SQ_POST: begin
				m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				frac_q <= {frac_q[LOG_FRAC-2:0], sq_t[32]};
				it_q   <= it_q + 6'd1;
			end
			S_LN_POST: begin
				numsh_q   <= mul_post(acc_q, SH_LN, 1'b0);
				rem_q     <= '0;
				quo_q     <= '0;
				over_q    <= 1'b0;
				div_cnt_q <= '0;
			end
			S_DIV: begin
				numsh_q   <= {numsh_q[62:0], 1'b0};
				rem_q     <= div_ge ? r_sub[63:0] : r_sh[63:0];
				quo_q     <= {quo_q[REG_W-2:0], div_ge};
				over_q    <= over_q | quo_q[REG_W-1];
				div_cnt_q <= div_cnt_q + 7'd1;
			end
			S_FIN: begin
				if (fin_go) begin
					for (int i = 0; i < 4; i++) out_c_q[i] <= c_q[i];
					out_time_q   <= time_q;
					out_chosen_q <= chosen_q;
					out_status_q <= status_q;
					out_crowd_q  <= crowd_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign wild_single     = out_c_q[0];
	assign wild_fused      = out_c_q[1];
	assign mut_single      = out_c_q[2];
	assign mut_fused       = out_c_q[3];
	assign sim_time        = out_time_q;
	assign chosen_reaction = out_chosen_q;
	assign status          = out_status_q;
	assign crowd_warning   = out_crowd_q;

endmodule
